/* hw/rtl/ets_pkg.sv */
`timescale 1ns / 1ps

package ets_pkg;

  typedef enum logic [2:0] {
    CMD_ADD_PERIODIC = 3'd0,
    CMD_ADD_ONESHOT  = 3'd1,
    CMD_CANCEL       = 3'd2,
    CMD_EXTEND       = 3'd3,
    CMD_RUN_PERIODIC = 3'd4,
    CMD_RUN_ONESHOT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  // countdown value that marks a periodic slot
  localparam logic [15:0] PERIODIC_MARK = 16'hFFFF;
  localparam logic [15:0] SAT_MAX       = 16'h7FFF;
  localparam logic [15:0] SAT_MIN       = 16'h8000;

endpackage

/* hw/rtl/event_timer_slot_table.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | in_valid_i / in_ready_o | command, event_id, event_arg, count, phase
// out     | output    | out_valid_o/ out_ready_i| status, fired, fired_id, fired_arg, last
//
// One word is taken at a time: accept, then one slot per cycle from the slot RAM
// (registered read) unless the output stalls, then flush; unused commands skip the scan.
// Adds, cancels and extends stop the scan at the first hit; runs scan all slots.
// A fired slot is held until the next fire releases it, or the flush does and sets last.
// Reset clears the slot valid flops at once; RAM contents need no clearing pass.
// A stalled output holds the scan; a new word is taken while the final result waits.
module event_timer_slot_table
  import ets_pkg::*;
#(
  parameter int SLOT_COUNT    = 20,
  parameter int EVENT_ID_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [7:0]         event_id_i,
  input  logic signed [15:0] event_arg_i,
  input  logic signed [15:0] count_i,
  input  logic [1:0]         phase_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               fired_o,
  output logic [7:0]         fired_id_o,
  output logic signed [15:0] fired_arg_o,
  output logic               last_o
);

  localparam int IdW  = (EVENT_ID_BITS < 8) ? EVENT_ID_BITS : 8;
  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [1:0]     phase;
    logic [IdW-1:0] id;
    logic [15:0]    arg;
    logic [15:0]    cd;
  } slot_t;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;

  cmd_e           cmd_q;
  logic [IdW-1:0] id_q;
  logic [15:0]    arg_q, cnt_q;
  logic [1:0]     ph_q;
  status_e        res_q, res_d;

  logic           pend_v_q, pend_v_d;
  logic [IdW-1:0] pend_id_q, pend_id_d;
  logic [15:0]    pend_arg_q, pend_arg_d;

  logic           out_v_q, out_v_d;
  status_e        status_q, status_d;
  logic           fired_q, fired_d;
  logic [IdW-1:0] fid_q, fid_d;
  logic [15:0]    farg_q, farg_d;
  logic           last_q, last_d;

  slot_t mem [SLOT_COUNT];
  slot_t rdata_q, wdata;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_raddr;

  logic go, accept, active, id_hit, ph_hit, found, fire, at_end, out_load;
  logic [16:0] sum;
  logic [15:0] cd_sat, cd_dec;

  assign go     = !out_v_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign active = valid_q[idx_q] && (rdata_q.phase != 2'd0);
  assign id_hit = active && (rdata_q.id == id_q);
  assign ph_hit = active && (rdata_q.phase == ph_q);
  assign at_end = (idx_q == LastIdx);

  assign sum    = {rdata_q.cd[15], rdata_q.cd} + {cnt_q[15], cnt_q};
  assign cd_sat = (sum[16] != sum[15]) ? (sum[16] ? SAT_MIN : SAT_MAX) : sum[15:0];
  assign cd_dec = rdata_q.cd - 16'd1;

  // slot RAM: write back the slot in hand, read the next one
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_q] <= wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (command_i <= CMD_RUN_ONESHOT) ? S_SCAN : S_FLUSH;
        end
      end
      S_SCAN: begin
        if (go && (found || at_end)) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d      = idx_q;
    valid_d    = valid_q;
    res_d      = res_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    pend_arg_d = pend_arg_q;
    status_d   = status_q;
    fired_d    = fired_q;
    fid_d      = fid_q;
    farg_d     = farg_q;
    last_d     = last_q;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    wdata      = rdata_q;
    found      = 1'b0;
    fire       = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        // ready is high throughout idle, so valid alone marks the accept
        if (in_valid_i) begin
          idx_d    = '0;
          mem_re   = 1'b1;
          res_d    = ST_OK;
          pend_v_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (go) begin
          unique case (cmd_q)
            CMD_ADD_PERIODIC, CMD_ADD_ONESHOT: begin
              if (!active) begin
                found          = 1'b1;
                mem_we         = 1'b1;
                wdata.phase    = ph_q;
                wdata.id       = id_q;
                wdata.arg      = arg_q;
                wdata.cd       = (cmd_q == CMD_ADD_PERIODIC) ? PERIODIC_MARK : cnt_q;
                valid_d[idx_q] = 1'b1;
              end
            end
            CMD_CANCEL: begin
              if (id_hit) begin
                found          = 1'b1;
                valid_d[idx_q] = 1'b0;
              end
            end
            CMD_EXTEND: begin
              if (id_hit) begin
                found    = 1'b1;
                mem_we   = 1'b1;
                wdata.cd = cd_sat;
              end
            end
            CMD_RUN_PERIODIC: begin
              fire = ph_hit && (rdata_q.cd == PERIODIC_MARK);
            end
            CMD_RUN_ONESHOT: begin
              if (ph_hit && !rdata_q.cd[15] && (rdata_q.cd != 16'd0)) begin
                mem_we   = 1'b1;
                wdata.cd = cd_dec;
                if (cd_dec == 16'd0) begin
                  fire           = 1'b1;
                  valid_d[idx_q] = 1'b0;
                end
              end
            end
            default: ;
          endcase

          if (!found && at_end) begin
            if (cmd_q == CMD_ADD_PERIODIC || cmd_q == CMD_ADD_ONESHOT) res_d = ST_FULL;
            if (cmd_q == CMD_CANCEL || cmd_q == CMD_EXTEND) res_d = ST_NOT_FOUND;
          end

          // a new fire releases the held one, known now not to be last
          if (fire) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              status_d = ST_OK;
              fired_d  = 1'b1;
              fid_d    = pend_id_q;
              farg_d   = pend_arg_q;
              last_d   = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_id_d  = rdata_q.id;
            pend_arg_d = rdata_q.arg;
          end

          if (!found && !at_end) begin
            idx_d     = IdxW'(idx_q + 1'b1);
            mem_re    = 1'b1;
            mem_raddr = idx_d;
          end
        end
      end
      S_FLUSH: begin
        if (go) begin
          out_load = 1'b1;
          status_d = res_q;
          fired_d  = pend_v_q;
          fid_d    = pend_v_q ? pend_id_q : '0;
          farg_d   = pend_v_q ? pend_arg_q : 16'd0;
          last_d   = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_load) out_v_d = 1'b1;
    else if (out_ready_i) out_v_d = 1'b0;
    else out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    res_q      <= res_d;
    pend_id_q  <= pend_id_d;
    pend_arg_q <= pend_arg_d;
    status_q   <= status_d;
    fired_q    <= fired_d;
    fid_q      <= fid_d;
    farg_q     <= farg_d;
    last_q     <= last_d;
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= IdW'(event_id_i);
      arg_q <= event_arg_i;
      cnt_q <= count_i;
      ph_q  <= phase_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = status_q;
  assign fired_o     = fired_q;
  assign fired_id_o  = 8'(fid_q);
  assign fired_arg_o = farg_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("held fire word left over at idle");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (status_o == ST_OK))
    else $error("fired word with non-ok status");

  a_nofire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fired_o) |-> (fired_id_o == 8'd0 && fired_arg_o == 16'sd0))
    else $error("unfired word carries id or arg");

  a_notlast_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> fired_o)
    else $error("non-final word that did not fire");
`endif

endmodule

/* dv/tb_event_timer_slot_table.sv */
`timescale 1ns / 1ps

module tb_event_timer_slot_table;
  import ets_pkg::*;

  localparam int SLOTS        = 20;
  localparam int RANDOM_WORDS = 128;
  localparam int PAUSE_AT     = 100;
  localparam int HOLD_AT      = 70;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 40;

  // command codes the block leaves unused
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  typedef enum int {
    EP_FILL,
    EP_TICK,
    EP_MIXED
  } episode_e;

  // one input word; typed set means the single result is given by status
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [15:0] arg;
    logic [15:0] cnt;
    logic [1:0]  ph;
    logic        typed;
    logic [1:0]  status;
  } timer_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [7:0]  id;
    logic [15:0] arg;
    logic        last;
  } slot_result_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  timer_word_t cur = '0;

  logic               in_ready;
  logic               out_valid;
  logic [1:0]         status;
  logic               fired;
  logic [7:0]         fired_id;
  logic signed [15:0] fired_arg;
  logic               last_w;

  // timer table kept by the testbench
  logic [1:0]         tbl_phase [SLOTS];
  logic [7:0]         tbl_event [SLOTS];
  logic [15:0]        tbl_arg   [SLOTS];
  logic signed [15:0] tbl_count [SLOTS];

  slot_result_t fresh_results [$];
  slot_result_t due_results [$];
  int errors   = 0;
  int words_in = 0;

  event_timer_slot_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (cur.cmd),
    .event_id_i  (cur.id),
    .event_arg_i (cur.arg),
    .count_i     (cur.cnt),
    .phase_i     (cur.ph),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .fired_o     (fired),
    .fired_id_o  (fired_id),
    .fired_arg_o (fired_arg),
    .last_o      (last_w)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (tbl_phase[i]) tbl_phase[i] = 2'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void step_slot_table(input timer_word_t w);
    int hit;
    int sum;
    int i;
    logic fire;
    slot_result_t r;
    hit = -1;
    r = '0;
    r.last = 1'b1;
    fresh_results.delete();
    case (w.cmd)
      CMD_ADD_PERIODIC, CMD_ADD_ONESHOT: begin
        for (i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_phase[i] == 2'd0) hit = i;
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          // a phase-zero add writes the slot but leaves it free
          tbl_phase[hit] = w.ph;
          tbl_event[hit] = w.id;
          tbl_arg[hit]   = w.arg;
          tbl_count[hit] = (w.cmd == CMD_ADD_PERIODIC) ? PERIODIC_MARK : w.cnt;
        end
        fresh_results.push_back(r);
      end
      CMD_CANCEL, CMD_EXTEND: begin
        for (i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_phase[i] != 2'd0 && tbl_event[i] == w.id) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (w.cmd == CMD_CANCEL) begin
          tbl_phase[hit] = 2'd0;
        end else begin
          sum = int'(tbl_count[hit]) + int'($signed(w.cnt));
          if (sum > 32767) sum = 32767;
          if (sum < -32768) sum = -32768;
          tbl_count[hit] = sum[15:0];
        end
        fresh_results.push_back(r);
      end
      CMD_RUN_PERIODIC, CMD_RUN_ONESHOT: begin
        if (w.ph != 2'd0) begin
          for (i = 0; i < SLOTS; i++) begin
            fire = 1'b0;
            if (tbl_phase[i] == w.ph) begin
              if (w.cmd == CMD_RUN_PERIODIC) begin
                fire = (tbl_count[i] == PERIODIC_MARK);
              end else if (tbl_count[i] > 0) begin
                tbl_count[i] = tbl_count[i] - 16'sd1;
                if (tbl_count[i] == 0) begin
                  tbl_phase[i] = 2'd0;
                  fire = 1'b1;
                end
              end
            end
            if (fire) begin
              r = '0;
              r.fired = 1'b1;
              r.id    = tbl_event[i];
              r.arg   = tbl_arg[i];
              fresh_results.push_back(r);
            end
          end
        end
        if (fresh_results.size() == 0) begin
          r = '0;
          r.last = 1'b1;
          fresh_results.push_back(r);
        end else begin
          r = fresh_results.pop_back();
          r.last = 1'b1;
          fresh_results.push_back(r);
        end
      end
      default: fresh_results.push_back(r);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor_blk
    slot_result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        words_in++;
        step_slot_table(cur);
        if (cur.typed) begin
          want = '0;
          want.status = cur.status;
          want.last   = 1'b1;
          due_results.push_back(want);
        end else begin
          foreach (fresh_results[k]) due_results.push_back(fresh_results[k]);
        end
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual id %0h arg %0h",
                     $time, fired_id, fired_arg);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, status);
          check_field("fired", want.fired, fired);
          check_field("fired_id", want.id, fired_id);
          check_field("fired_arg", want.arg, fired_arg);
          check_field("last", want.last, last_w);
        end
      end
    end
  end

  // stretches with random gaps are mixed at random with stretches at full rate
  function automatic int next_gap(inout int left, inout bit busy);
    if (left == 0) begin
      left = $urandom_range(4, 30);
      busy = ($urandom_range(0, 2) != 0);
    end
    left--;
    return busy ? $urandom_range(0, 9) : 0;
  endfunction

  function automatic timer_word_t mk(input logic [2:0] cmd, input logic [7:0] id,
                                     input logic [15:0] arg, input logic [15:0] cnt,
                                     input logic [1:0] ph, input logic typed,
                                     input logic [1:0] st);
    timer_word_t w;
    w.cmd    = cmd;
    w.id     = id;
    w.arg    = arg;
    w.cnt    = cnt;
    w.ph     = ph;
    w.typed  = typed;
    w.status = st;
    return w;
  endfunction

  function automatic timer_word_t rand_word(input episode_e ep);
    timer_word_t w;
    int r;
    w = '0;
    // small id pool so cancels and extends mostly hit
    w.id  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
    w.arg = 16'($urandom);
    w.ph  = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    r = $urandom_range(0, 9);
    if (r < 6) w.cnt = 16'($urandom_range(1, 4));
    else if (r == 6) w.cnt = PERIODIC_MARK;
    else if (r == 7) w.cnt = 16'h0000;
    else w.cnt = 16'($urandom);
    r = $urandom_range(0, 19);
    case (ep)
      EP_FILL: begin
        if (r < 9) w.cmd = CMD_ADD_PERIODIC;
        else if (r < 18) w.cmd = CMD_ADD_ONESHOT;
        else w.cmd = CMD_CANCEL;
      end
      EP_TICK: begin
        if (r < 8) w.cmd = CMD_RUN_ONESHOT;
        else if (r < 14) w.cmd = CMD_RUN_PERIODIC;
        else if (r < 16) w.cmd = CMD_EXTEND;
        else if (r < 18) w.cmd = CMD_ADD_ONESHOT;
        else w.cmd = CMD_CANCEL;
      end
      default: begin
        if (r < 3) w.cmd = CMD_ADD_PERIODIC;
        else if (r < 6) w.cmd = CMD_ADD_ONESHOT;
        else if (r < 9) w.cmd = CMD_CANCEL;
        else if (r < 12) w.cmd = CMD_EXTEND;
        else if (r < 15) w.cmd = CMD_RUN_PERIODIC;
        else if (r < 18) w.cmd = CMD_RUN_ONESHOT;
        else if (r == 18) w.cmd = CMD_UNUSED_6;
        else w.cmd = CMD_UNUSED_7;
      end
    endcase
    return w;
  endfunction

  task automatic send_word(input timer_word_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cur      <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: per-result stall, plus one long hold-off so the block backs up
  initial begin : receiver
    int left;
    bit busy;
    bit held;
    int gap;
    left = 0;
    busy = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = next_gap(left, busy);
      if (!held && words_in >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    timer_word_t rows [$];
    int left;
    bit busy;
    int sent;
    int len;
    episode_e ep;
    left = 0;
    busy = 1'b0;

    // lookups on an empty table, then a table with every kind of slot
    rows.push_back(mk(CMD_CANCEL,       8'd5,   16'h0000, 16'h0000, 2'd1, 1'b1, ST_NOT_FOUND));
    rows.push_back(mk(CMD_EXTEND,       8'd5,   16'h0000, 16'h0001, 2'd1, 1'b1, ST_NOT_FOUND));
    rows.push_back(mk(CMD_RUN_PERIODIC, 8'd1,   16'h0000, 16'h0000, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_PERIODIC, 8'd255, 16'h7FFF, 16'h0000, 2'd3, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_PERIODIC, 8'd1,   16'h8000, 16'h0000, 2'd3, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_ONESHOT,  8'd2,   16'h5555, 16'h0001, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_ONESHOT,  8'd3,   16'hFFFF, 16'h7FFF, 2'd2, 1'b1, ST_OK));
    // one-shot with the periodic mark as its count
    rows.push_back(mk(CMD_ADD_ONESHOT,  8'd4,   16'hAAAA, 16'hFFFF, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_ONESHOT,  8'd6,   16'h0001, 16'h0000, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_ADD_ONESHOT,  8'd7,   16'h1234, 16'h8000, 2'd2, 1'b1, ST_OK));
    // phase-zero add leaves the slot free
    rows.push_back(mk(CMD_ADD_PERIODIC, 8'd8,   16'h4321, 16'h0000, 2'd0, 1'b1, ST_OK));
    rows.push_back(mk(CMD_RUN_PERIODIC, 8'd1,   16'h0000, 16'h0000, 2'd3, 1'b0, ST_OK));
    rows.push_back(mk(CMD_RUN_PERIODIC, 8'd1,   16'h0000, 16'h0000, 2'd1, 1'b0, ST_OK));
    rows.push_back(mk(CMD_RUN_ONESHOT,  8'd1,   16'h0000, 16'h0000, 2'd1, 1'b0, ST_OK));
    rows.push_back(mk(CMD_RUN_ONESHOT,  8'd1,   16'h0000, 16'h0000, 2'd0, 1'b1, ST_OK));
    rows.push_back(mk(CMD_RUN_PERIODIC, 8'd1,   16'h0000, 16'h0000, 2'd0, 1'b1, ST_OK));
    // saturating extends, and a periodic slot turned into a one-shot
    rows.push_back(mk(CMD_EXTEND,       8'd3,   16'h0000, 16'h7FFF, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_EXTEND,       8'd7,   16'h0000, 16'h8000, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_EXTEND,       8'd255, 16'h0000, 16'h0002, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_RUN_PERIODIC, 8'd1,   16'h0000, 16'h0000, 2'd3, 1'b0, ST_OK));
    rows.push_back(mk(CMD_RUN_ONESHOT,  8'd1,   16'h0000, 16'h0000, 2'd3, 1'b0, ST_OK));
    rows.push_back(mk(CMD_RUN_ONESHOT,  8'd1,   16'h0000, 16'h0000, 2'd2, 1'b0, ST_OK));
    rows.push_back(mk(CMD_CANCEL,       8'd1,   16'h0000, 16'h0000, 2'd1, 1'b1, ST_OK));
    rows.push_back(mk(CMD_UNUSED_6,     8'd9,   16'hFFFF, 16'hFFFF, 2'd3, 1'b1, ST_OK));
    rows.push_back(mk(CMD_UNUSED_7,     8'd9,   16'hFFFF, 16'hFFFF, 2'd3, 1'b1, ST_OK));

    wait (rst_ni);
    @(posedge clk_i);
    foreach (rows[k]) send_word(rows[k], next_gap(left, busy));

    // first episode fills the table past capacity
    sent = 0;
    ep   = EP_FILL;
    len  = 24;
    while (sent < RANDOM_WORDS) begin
      repeat (len) begin
        send_word(rand_word(ep), next_gap(left, busy));
        sent++;
        if (sent == PAUSE_AT) wait_idle();
      end
      ep  = episode_e'($urandom_range(0, 2));
      len = $urandom_range(6, 20);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
